[rtl/core/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, codes and the per-entry fade function of the palette fade
// engine.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int PALETTE_ENTRIES_DEF = 64;
  localparam int MODE_W              = 3;
  localparam int IDX_W               = 6;
  localparam int COLOR_W             = 16;
  localparam int SPEED_W             = 8;
  localparam int QUEUE_DEPTH         = 4;
  localparam int NUM_FIELDS          = 3;

  // red, green, blue fields of a color word and their unit step
  localparam logic [COLOR_W-1:0] FIELD_MASK [NUM_FIELDS] = '{16'h000E, 16'h00E0, 16'h0E00};
  localparam logic [COLOR_W-1:0] FIELD_ONE  [NUM_FIELDS] = '{16'h0002, 16'h0020, 16'h0200};

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_DISP = 3'd0,
    MODE_WR_TGT  = 3'd1,
    MODE_SWAP    = 3'd2,
    MODE_START   = 3'd3,
    MODE_STOP    = 3'd4,
    MODE_TICK    = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t              op;
    logic               in_range;
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_STEP_END,
    ST_EMIT,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               moved;
  } fade_res_t;

  // Move each 3-bit field one step toward the goal; other bits untouched.
  function automatic fade_res_t fade_entry(logic [COLOR_W-1:0] cur,
                                           logic [COLOR_W-1:0] goal);
    fade_res_t          r;
    logic [COLOR_W-1:0] v;
    logic [COLOR_W-1:0] c;
    logic [COLOR_W-1:0] g;
    v       = cur;
    r.moved = 1'b0;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      c = v & FIELD_MASK[k];
      g = goal & FIELD_MASK[k];
      if (c < g) begin
        v       = v + FIELD_ONE[k];
        r.moved = 1'b1;
      end else if (c > g) begin
        v       = v - FIELD_ONE[k];
        r.moved = 1'b1;
      end
    end
    r.color = v;
    return r;
  endfunction

endpackage

[rtl/core/pfe_front.sv]
// ----------------------------------------------------------------------------
// pfe_front
// Accepts input items, decodes the mode and range-checks the entry index,
// then pushes a command into the queue. Unused modes are dropped here.
// ----------------------------------------------------------------------------
module pfe_front #(
  parameter int PALETTE_ENTRIES = pfe_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pfe_pkg::MODE_W-1:0]  mode,
  input  logic [pfe_pkg::IDX_W-1:0]   entry_index,
  input  logic [pfe_pkg::COLOR_W-1:0] color_value,
  input  logic                        q_full,
  output logic                        q_push,
  output pfe_pkg::cmd_t               q_cmd
);

  logic known;

  assign in_ready = !q_full;

  always_comb begin
    known = 1'b1;
    unique case (pfe_pkg::mode_t'(mode))
      pfe_pkg::MODE_WR_DISP, pfe_pkg::MODE_WR_TGT, pfe_pkg::MODE_SWAP,
      pfe_pkg::MODE_START, pfe_pkg::MODE_STOP, pfe_pkg::MODE_TICK: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    q_cmd.op       = pfe_pkg::mode_t'(mode);
    q_cmd.in_range = (32'(entry_index) < PALETTE_ENTRIES);
    q_cmd.index    = entry_index;
    q_cmd.color    = color_value;
  end

  assign q_push = in_valid && !q_full && known;

endmodule

[rtl/core/pfe_queue.sv]
// ----------------------------------------------------------------------------
// pfe_queue
// Short command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module pfe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pfe_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          cmd_valid,
  output pfe_pkg::cmd_t cmd
);

  localparam int PW = $clog2(pfe_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(pfe_pkg::QUEUE_DEPTH + 1);

  pfe_pkg::cmd_t  slots [pfe_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full      = (count == CW'(pfe_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(pfe_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != CW'(pfe_pkg::QUEUE_DEPTH)) |-> (PW'(wr_ptr - rd_ptr) == PW'(count)))
    else $error("queue pointers disagree with count");

endmodule

[rtl/core/pfe_back.sv]
// ----------------------------------------------------------------------------
// pfe_back
// Executes queued commands: palette writes, swap, fade control and frame
// ticks. A tick may fade all entries; then it emits them all or a status item.
// ----------------------------------------------------------------------------
module pfe_back #(
  parameter int PALETTE_ENTRIES = pfe_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pfe_pkg::SPEED_W-1:0] cfg_wdata,
  input  logic                        cmd_valid,
  input  pfe_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_color,
  output logic [pfe_pkg::IDX_W-1:0]   cram_index,
  output logic [pfe_pkg::COLOR_W-1:0] cram_color,
  output logic                        fade_active,
  output logic                        last
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam int CW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
  localparam logic [CW-1:0] CNT_END   = CW'(PALETTE_ENTRIES);

  pfe_pkg::state_t state, state_next;

  logic [pfe_pkg::COLOR_W-1:0] mem_a [PALETTE_ENTRIES];
  logic [pfe_pkg::COLOR_W-1:0] mem_b [PALETTE_ENTRIES];
  logic [pfe_pkg::COLOR_W-1:0] rdata_a;
  logic [pfe_pkg::COLOR_W-1:0] rdata_b;

  logic [pfe_pkg::SPEED_W-1:0] fade_speed;
  logic [pfe_pkg::SPEED_W-1:0] frame_count, frame_count_next;
  logic [pfe_pkg::SPEED_W-1:0] fc_inc;
  logic                        b_disp, b_disp_next;
  logic                        dirty, dirty_next;
  logic                        fading, fading_next;
  logic [CW-1:0]               cnt, cnt_next;
  logic                        e1_vld, e1_vld_next;
  logic [AW-1:0]               e1_addr;

  logic                        tick;
  logic                        step_hit;
  logic                        rd_en;
  logic                        out_free;
  logic                        s1_move;
  logic                        e1_last;
  logic                        we_disp, we_tgt, we_a, we_b;
  logic [AW-1:0]               waddr;
  logic [pfe_pkg::COLOR_W-1:0] wdata;
  logic [pfe_pkg::COLOR_W-1:0] disp_q, tgt_q;
  pfe_pkg::fade_res_t          faded;

  assign disp_q   = b_disp ? rdata_b : rdata_a;
  assign tgt_q    = b_disp ? rdata_a : rdata_b;
  assign faded    = pfe_pkg::fade_entry(disp_q, tgt_q);
  assign out_free = !out_valid || out_ready;
  assign e1_last  = (e1_addr == LAST_ADDR);
  assign fc_inc   = frame_count + 1'b1;
  assign cmd_pop  = (state == pfe_pkg::ST_IDLE) && cmd_valid;
  assign tick     = cmd_pop && (cmd.op == pfe_pkg::MODE_TICK);
  assign step_hit = fading && (fc_inc == fade_speed);
  assign s1_move  = (state == pfe_pkg::ST_EMIT) && e1_vld && out_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfe_pkg::ST_IDLE: begin
        if (tick) begin
          if (step_hit) begin
            state_next = pfe_pkg::ST_STEP;
          end else if (dirty) begin
            state_next = pfe_pkg::ST_EMIT;
          end else begin
            state_next = pfe_pkg::ST_STATUS;
          end
        end
      end
      pfe_pkg::ST_STEP: begin
        if (e1_vld && e1_last) begin
          state_next = pfe_pkg::ST_STEP_END;
        end
      end
      pfe_pkg::ST_STEP_END: begin
        state_next = dirty ? pfe_pkg::ST_EMIT : pfe_pkg::ST_STATUS;
      end
      pfe_pkg::ST_EMIT: begin
        if (s1_move && e1_last) begin
          state_next = pfe_pkg::ST_IDLE;
        end
      end
      pfe_pkg::ST_STATUS: begin
        if (out_free) begin
          state_next = pfe_pkg::ST_IDLE;
        end
      end
      default: state_next = pfe_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    frame_count_next = frame_count;
    b_disp_next      = b_disp;
    dirty_next       = dirty;
    fading_next      = fading;
    rd_en            = 1'b0;
    we_disp          = 1'b0;
    we_tgt           = 1'b0;
    waddr            = AW'(cmd.index);
    wdata            = cmd.color;
    unique case (state)
      pfe_pkg::ST_IDLE: begin
        if (cmd_pop) begin
          case (cmd.op)
            pfe_pkg::MODE_WR_DISP: begin
              dirty_next = 1'b1;
              we_disp    = cmd.in_range;
            end
            pfe_pkg::MODE_WR_TGT: begin
              we_tgt = cmd.in_range;
            end
            pfe_pkg::MODE_SWAP: begin
              b_disp_next = !b_disp;
              dirty_next  = 1'b1;
            end
            pfe_pkg::MODE_START: begin
              frame_count_next = '0;
              fading_next      = 1'b1;
            end
            pfe_pkg::MODE_STOP: begin
              fading_next = 1'b0;
            end
            pfe_pkg::MODE_TICK: begin
              if (step_hit) begin
                frame_count_next = '0;
                dirty_next       = 1'b0;
              end else begin
                if (fading) begin
                  frame_count_next = fc_inc;
                end
                dirty_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      pfe_pkg::ST_STEP: begin
        rd_en = (cnt != CNT_END);
        if (e1_vld) begin
          we_disp = 1'b1;
          waddr   = e1_addr;
          wdata   = faded.color;
          if (faded.moved) begin
            dirty_next = 1'b1;
          end
        end
      end
      pfe_pkg::ST_STEP_END: begin
        if (!dirty) begin
          fading_next = 1'b0;
        end
        dirty_next = 1'b0;
      end
      pfe_pkg::ST_EMIT: begin
        rd_en = (cnt != CNT_END) && (!e1_vld || s1_move);
      end
      pfe_pkg::ST_STATUS: ;
      default: ;
    endcase
  end

  assign we_a = b_disp ? we_tgt : we_disp;
  assign we_b = b_disp ? we_disp : we_tgt;

  always_comb begin
    if (rd_en) begin
      cnt_next = cnt + 1'b1;
    end else if (state == pfe_pkg::ST_IDLE || state == pfe_pkg::ST_STEP_END) begin
      cnt_next = '0;
    end else begin
      cnt_next = cnt;
    end
    // the step pass writes back every cycle; the emit pass holds on stall
    if (rd_en) begin
      e1_vld_next = 1'b1;
    end else if (state == pfe_pkg::ST_STEP || s1_move) begin
      e1_vld_next = 1'b0;
    end else begin
      e1_vld_next = e1_vld;
    end
  end

  // palettes: one write and one registered read per memory per cycle
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a <= mem_a[cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_b <= mem_b[cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      e1_addr <= cnt[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pfe_pkg::ST_IDLE;
      fade_speed  <= '0;
      frame_count <= '0;
      b_disp      <= 1'b0;
      dirty       <= 1'b0;
      fading      <= 1'b0;
      cnt         <= '0;
      e1_vld      <= 1'b0;
    end else begin
      state       <= state_next;
      frame_count <= frame_count_next;
      b_disp      <= b_disp_next;
      dirty       <= dirty_next;
      fading      <= fading_next;
      cnt         <= cnt_next;
      e1_vld      <= e1_vld_next;
      if (cfg_we) begin
        fade_speed <= cfg_wdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move || (state == pfe_pkg::ST_STATUS && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      is_color    <= 1'b1;
      cram_index  <= pfe_pkg::IDX_W'(e1_addr);
      cram_color  <= disp_q;
      fade_active <= fading;
      last        <= e1_last;
    end else if (state == pfe_pkg::ST_STATUS && out_free) begin
      is_color    <= 1'b0;
      cram_index  <= '0;
      cram_color  <= '0;
      fade_active <= fading;
      last        <= 1'b1;
    end
  end

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == pfe_pkg::ST_EMIT) |-> !(we_a || we_b))
    else $error("palette written during emit pass");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == pfe_pkg::ST_EMIT && e1_vld && !s1_move) |=> (e1_vld && $stable(e1_addr)))
    else $error("stalled emit entry lost");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_END)
    else $error("entry counter past end");

  a_step_end_origin: assert property (@(posedge clk) disable iff (rst)
    (state == pfe_pkg::ST_STEP_END) |-> ($past(state) == pfe_pkg::ST_STEP))
    else $error("step end entered without a step pass");

endmodule

[rtl/core/palette_fade_engine_top.sv]
// ----------------------------------------------------------------------------
// palette_fade_engine_top
// Palette fade engine: displayed and target palettes with a per-frame fade.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   input    | in_valid / in_ready    | mode, entry_index, color_value
//   output   | out_valid / out_ready  | is_color, cram_index, cram_color,
//            |                        | fade_active, last
//   config   | cfg_we                 | cfg_wdata (fade_speed)
//
// Non-tick items are executed by the back end after passing a 4-deep queue.
// A tick with a dirty palette emits N = PALETTE_ENTRIES entries at one per
// cycle while out_ready allows, else a single status item; a tick that runs
// a fade step first walks all entries through the palette read ports.
// Reset is synchronous; palette contents are not cleared.
// Output backpressure holds the emit pass and the status item, never the
// fade step; the front keeps filling the queue while the back is busy.
// ----------------------------------------------------------------------------
module palette_fade_engine_top #(
  parameter int PALETTE_ENTRIES = pfe_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pfe_pkg::SPEED_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pfe_pkg::MODE_W-1:0]  mode,
  input  logic [pfe_pkg::IDX_W-1:0]   entry_index,
  input  logic [pfe_pkg::COLOR_W-1:0] color_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_color,
  output logic [pfe_pkg::IDX_W-1:0]   cram_index,
  output logic [pfe_pkg::COLOR_W-1:0] cram_color,
  output logic                        fade_active,
  output logic                        last
);

  logic          q_full;
  logic          q_push;
  pfe_pkg::cmd_t q_cmd;
  logic          q_pop;
  logic          q_valid;
  pfe_pkg::cmd_t q_head;

  pfe_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .entry_index (entry_index),
    .color_value (color_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  pfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .cmd_valid (q_valid),
    .cmd       (q_head)
  );

  pfe_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd_valid   (q_valid),
    .cmd         (q_head),
    .cmd_pop     (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .is_color    (is_color),
    .cram_index  (cram_index),
    .cram_color  (cram_color),
    .fade_active (fade_active),
    .last        (last)
  );

endmodule
